>>> rtl/zksq_pkg.sv
// Shared types and constants for the square-product verifier.
// Used by the controller, the datapath, the reducer and the top level.
package zksq_pkg;

    localparam int KEY_COUNT_DEF = 8;
    localparam int VAL_W         = 31;
    localparam int PROD_W        = 2 * VAL_W;
    localparam int MASK_W        = 8;
    localparam int MASK_IDX_W    = $clog2(MASK_W);
    localparam int STEP_W        = $clog2(PROD_W + 1);

    localparam logic [VAL_W-1:0]  MOD_RESET = 31'h7FFF_FFFF;
    localparam logic [VAL_W-1:0]  MOD_MIN   = 31'd2;
    localparam logic [STEP_W-1:0] STEPS_VAL  = STEP_W'(VAL_W);
    localparam logic [STEP_W-1:0] STEPS_PROD = STEP_W'(PROD_W);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RGO,
        S_RWAIT,
        S_SQMUL,
        S_SQGO,
        S_SQWAIT,
        S_KCHK,
        S_KRD,
        S_KMUL,
        S_KGO,
        S_KWAIT,
        S_KNEXT,
        S_CMP,
        S_OUT
    } t_state;

    typedef enum logic {
        RED_RESP,
        RED_PROD
    } t_red_src;

    typedef enum logic {
        MUL_SQ,
        MUL_KEY
    } t_mul_src;

    typedef enum logic [1:0] {
        ST_NONE,
        ST_RESP,
        ST_LEFT,
        ST_RIGHT
    } t_store;

    typedef struct packed {
        logic                  load_key;
        logic                  capture;
        logic                  red_start;
        t_red_src              red_src;
        logic                  mul_en;
        t_mul_src              mul_src;
        logic                  key_rd;
        t_store                store;
        logic                  compare;
        logic [MASK_IDX_W-1:0] kidx;
    } t_dp_cmd;

    typedef struct packed {
        logic red_done;
        logic mask_bit;
    } t_dp_stat;

endpackage

>>> rtl/zksq_modred.sv
// Bit-serial modular reducer: one quotient bit per cycle, MSB first.
// Depends on zksq_pkg for widths.
module zksq_modred (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [zksq_pkg::PROD_W-1:0]   i_value,
    input  logic [zksq_pkg::STEP_W-1:0]   i_steps,
    input  logic [zksq_pkg::VAL_W-1:0]    i_modulus,
    output logic                          o_done,
    output logic [zksq_pkg::VAL_W-1:0]    o_rem
);

    logic [zksq_pkg::PROD_W-1:0] r_shift;
    logic [zksq_pkg::VAL_W-1:0]  r_rem;
    logic [zksq_pkg::STEP_W-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [zksq_pkg::VAL_W:0] w_trial;
    logic [zksq_pkg::VAL_W:0] w_mod;
    logic [zksq_pkg::VAL_W:0] w_diff;
    logic [zksq_pkg::VAL_W-1:0] n_rem;

    assign w_trial = {r_rem, r_shift[zksq_pkg::PROD_W-1]};
    assign w_mod   = {1'b0, i_modulus};
    assign w_diff  = w_trial - w_mod;

    always_comb begin
        if (w_trial >= w_mod) begin
            n_rem = w_diff[zksq_pkg::VAL_W-1:0];
        end else begin
            n_rem = w_trial[zksq_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - zksq_pkg::STEP_W'(1);
                if (r_cnt == zksq_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_value;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[zksq_pkg::PROD_W-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/zksq_dp.sv
// Datapath: modulus register, key table, operand registers, multiplier
// and the serial reducer. Depends on zksq_pkg and zksq_modred.
module zksq_dp #(
    parameter int KEY_COUNT = zksq_pkg::KEY_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wen,
    input  logic [zksq_pkg::VAL_W-1:0]       i_cfg_wdata,
    input  logic [2:0]                       i_key_index,
    input  logic [zksq_pkg::VAL_W-1:0]       i_key_word,
    input  logic [zksq_pkg::VAL_W-1:0]       i_commitment,
    input  logic [zksq_pkg::VAL_W-1:0]       i_response,
    input  logic [zksq_pkg::MASK_W-1:0]      i_challenge_mask,
    input  zksq_pkg::t_dp_cmd                i_cmd,
    output zksq_pkg::t_dp_stat               o_stat,
    output logic                             o_passed
);

    localparam int          KEY_IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam logic [31:0] KEY_LIMIT = 32'(KEY_COUNT);

    logic [zksq_pkg::VAL_W-1:0]  r_modulus;
    logic [zksq_pkg::VAL_W-1:0]  r_keys [KEY_COUNT];
    logic [zksq_pkg::VAL_W-1:0]  r_key;
    logic [zksq_pkg::VAL_W-1:0]  r_resp;
    logic [zksq_pkg::VAL_W-1:0]  r_left;
    logic [zksq_pkg::VAL_W-1:0]  r_right;
    logic [zksq_pkg::MASK_W-1:0] r_mask;
    logic [zksq_pkg::PROD_W-1:0] r_prod;
    logic                        r_passed;

    logic [KEY_IDX_W-1:0]        w_wr_addr;
    logic [KEY_IDX_W-1:0]        w_rd_addr;
    logic [zksq_pkg::VAL_W-1:0]  w_mul_a;
    logic [zksq_pkg::VAL_W-1:0]  w_mul_b;
    logic [zksq_pkg::PROD_W-1:0] w_red_in;
    logic [zksq_pkg::STEP_W-1:0] w_red_steps;
    logic                        w_red_done;
    logic [zksq_pkg::VAL_W-1:0]  w_red_rem;

    assign w_wr_addr = KEY_IDX_W'(i_key_index);
    assign w_rd_addr = KEY_IDX_W'(i_cmd.kidx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= zksq_pkg::MOD_RESET;
        end else if (i_cfg_wen) begin
            // clamp to the smallest usable modulus
            r_modulus <= (i_cfg_wdata < zksq_pkg::MOD_MIN) ? zksq_pkg::MOD_MIN : i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key && ({29'b0, i_key_index} < KEY_LIMIT)) begin
            r_keys[w_wr_addr] <= i_key_word;
        end
        if (i_cmd.key_rd) begin
            r_key <= r_keys[w_rd_addr];
        end
    end

    always_comb begin
        case (i_cmd.mul_src)
            zksq_pkg::MUL_SQ: begin
                w_mul_a = r_resp;
                w_mul_b = r_resp;
            end
            default: begin
                w_mul_a = r_right;
                w_mul_b = r_key;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.red_src)
            zksq_pkg::RED_RESP: begin
                // only the upper half carries data, so stop after VAL_W steps
                w_red_in    = {r_resp, {zksq_pkg::VAL_W{1'b0}}};
                w_red_steps = zksq_pkg::STEPS_VAL;
            end
            default: begin
                w_red_in    = r_prod;
                w_red_steps = zksq_pkg::STEPS_PROD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_resp  <= i_response;
            r_right <= i_commitment;
            r_mask  <= i_challenge_mask;
        end else begin
            case (i_cmd.store)
                zksq_pkg::ST_RESP:  r_resp  <= w_red_rem;
                zksq_pkg::ST_LEFT:  r_left  <= w_red_rem;
                zksq_pkg::ST_RIGHT: r_right <= w_red_rem;
                default: ;
            endcase
        end
        if (i_cmd.mul_en) begin
            r_prod <= zksq_pkg::PROD_W'(w_mul_a) * zksq_pkg::PROD_W'(w_mul_b);
        end
        if (i_cmd.compare) begin
            r_passed <= (r_left == r_right);
        end
    end

    zksq_modred u_modred (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.red_start),
        .i_value   (w_red_in),
        .i_steps   (w_red_steps),
        .i_modulus (r_modulus),
        .o_done    (w_red_done),
        .o_rem     (w_red_rem)
    );

    assign o_stat.red_done = w_red_done;
    assign o_stat.mask_bit = r_mask[i_cmd.kidx];
    assign o_passed        = r_passed;

endmodule

>>> rtl/zksq_ctrl.sv
// Controller state machine: sequences loads and the verify steps.
// Depends on zksq_pkg for the state enum and the command/status structs.
module zksq_ctrl #(
    parameter int KEY_COUNT = zksq_pkg::KEY_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                i_action,
    input  zksq_pkg::t_dp_stat  i_stat,
    output zksq_pkg::t_dp_cmd   o_cmd,
    output logic                busy,
    output logic                o_done
);

    localparam int IW    = zksq_pkg::MASK_IDX_W;
    localparam int LIMIT = (KEY_COUNT < zksq_pkg::MASK_W) ? KEY_COUNT : zksq_pkg::MASK_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(LIMIT - 1);

    zksq_pkg::t_state r_state;
    zksq_pkg::t_state n_state;
    logic [IW-1:0]    r_kidx;
    logic [IW-1:0]    n_kidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= zksq_pkg::S_IDLE;
            r_kidx  <= '0;
        end else begin
            r_state <= n_state;
            r_kidx  <= n_kidx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_kidx  = r_kidx;
        unique case (r_state)
            zksq_pkg::S_IDLE: begin
                n_kidx = '0;
                if (start && i_action) begin
                    n_state = zksq_pkg::S_RGO;
                end
            end
            zksq_pkg::S_RGO:   n_state = zksq_pkg::S_RWAIT;
            zksq_pkg::S_RWAIT: begin
                if (i_stat.red_done) begin
                    n_state = zksq_pkg::S_SQMUL;
                end
            end
            zksq_pkg::S_SQMUL: n_state = zksq_pkg::S_SQGO;
            zksq_pkg::S_SQGO:  n_state = zksq_pkg::S_SQWAIT;
            zksq_pkg::S_SQWAIT: begin
                if (i_stat.red_done) begin
                    n_state = zksq_pkg::S_KCHK;
                end
            end
            zksq_pkg::S_KCHK: begin
                // skip key words whose challenge bit is clear
                n_state = i_stat.mask_bit ? zksq_pkg::S_KRD : zksq_pkg::S_KNEXT;
            end
            zksq_pkg::S_KRD:  n_state = zksq_pkg::S_KMUL;
            zksq_pkg::S_KMUL: n_state = zksq_pkg::S_KGO;
            zksq_pkg::S_KGO:  n_state = zksq_pkg::S_KWAIT;
            zksq_pkg::S_KWAIT: begin
                if (i_stat.red_done) begin
                    n_state = zksq_pkg::S_KNEXT;
                end
            end
            zksq_pkg::S_KNEXT: begin
                if (r_kidx == LAST_IDX) begin
                    n_state = zksq_pkg::S_CMP;
                end else begin
                    n_kidx  = r_kidx + IW'(1);
                    n_state = zksq_pkg::S_KCHK;
                end
            end
            zksq_pkg::S_CMP: n_state = zksq_pkg::S_OUT;
            zksq_pkg::S_OUT: n_state = zksq_pkg::S_IDLE;
            default:         n_state = zksq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.red_src   = zksq_pkg::RED_PROD;
        o_cmd.mul_src   = zksq_pkg::MUL_KEY;
        o_cmd.store     = zksq_pkg::ST_NONE;
        o_cmd.kidx      = r_kidx;
        busy            = 1'b1;
        o_done          = 1'b0;
        unique case (r_state)
            zksq_pkg::S_IDLE: begin
                busy           = 1'b0;
                o_cmd.load_key = start && !i_action;
                o_cmd.capture  = start && i_action;
            end
            zksq_pkg::S_RGO: begin
                o_cmd.red_start = 1'b1;
                o_cmd.red_src   = zksq_pkg::RED_RESP;
            end
            zksq_pkg::S_RWAIT: begin
                if (i_stat.red_done) begin
                    o_cmd.store = zksq_pkg::ST_RESP;
                end
            end
            zksq_pkg::S_SQMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = zksq_pkg::MUL_SQ;
            end
            zksq_pkg::S_SQGO:  o_cmd.red_start = 1'b1;
            zksq_pkg::S_SQWAIT: begin
                if (i_stat.red_done) begin
                    o_cmd.store = zksq_pkg::ST_LEFT;
                end
            end
            zksq_pkg::S_KRD:  o_cmd.key_rd    = 1'b1;
            zksq_pkg::S_KMUL: o_cmd.mul_en    = 1'b1;
            zksq_pkg::S_KGO:  o_cmd.red_start = 1'b1;
            zksq_pkg::S_KWAIT: begin
                if (i_stat.red_done) begin
                    o_cmd.store = zksq_pkg::ST_RIGHT;
                end
            end
            zksq_pkg::S_CMP: o_cmd.compare = 1'b1;
            zksq_pkg::S_OUT: o_done        = 1'b1;
            default: ;
        endcase
    end

endmodule

>>> rtl/zk_square_product_verifier.sv
// Top level of the square-product identification verifier.
// Depends on zksq_pkg, zksq_ctrl and zksq_dp (which holds zksq_modred).
//
// Drive start with busy low to transfer one item. A load item (action 0)
// is taken in that single cycle, gives no result, and busy stays low. A
// verify item (action 1) raises busy until its result has been shown:
// o_passed is valid for exactly one cycle while o_done is high, and the
// receiver cannot stall it. A verify reduces the response, squares it and
// reduces the square, then checks each key position and, for each set
// challenge bit, multiplies by that key and reduces, then compares; the
// next item can be taken in the cycle after the result cycle. All
// reductions use the shared reducer, which retires one bit per cycle.
// Write the modulus only while busy is low; values below 2
// are stored as 2.
module zk_square_product_verifier #(
    parameter int KEY_COUNT = zksq_pkg::KEY_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wen,
    input  logic [zksq_pkg::VAL_W-1:0]   i_cfg_wdata,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_action,
    input  logic [2:0]                   i_key_index,
    input  logic [zksq_pkg::VAL_W-1:0]   i_key_word,
    input  logic [zksq_pkg::VAL_W-1:0]   i_commitment,
    input  logic [zksq_pkg::VAL_W-1:0]   i_response,
    input  logic [zksq_pkg::MASK_W-1:0]  i_challenge_mask,
    output logic                         o_done,
    output logic                         o_passed
);

    zksq_pkg::t_dp_cmd  w_cmd;
    zksq_pkg::t_dp_stat w_stat;

    zksq_ctrl #(
        .KEY_COUNT (KEY_COUNT)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .busy     (busy),
        .o_done   (o_done)
    );

    zksq_dp #(
        .KEY_COUNT (KEY_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wen        (i_cfg_wen),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_key_index      (i_key_index),
        .i_key_word       (i_key_word),
        .i_commitment     (i_commitment),
        .i_response       (i_response),
        .i_challenge_mask (i_challenge_mask),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_passed         (o_passed)
    );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for zk_square_product_verifier: key loads, proof checks, modulus phases.
// Depends on zksq_pkg and the verifier RTL. Verdicts are predicted in the bench and compared
// in order as each one is strobed out.
module tb_top;

    import zksq_pkg::*;

    localparam int KEYS        = KEY_COUNT_DEF;
    localparam int PER_PHASE   = 200;
    localparam int PHASES      = 8;
    localparam int CFG_SETTLE  = 4;
    localparam int TAIL_CYCLES = 700;
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    typedef struct {
        bit              is_cfg;
        bit [VAL_W-1:0]  cfg_val;
        bit              action;
        bit [2:0]        key_index;
        bit [VAL_W-1:0]  key_word;
        bit [VAL_W-1:0]  commitment;
        bit [VAL_W-1:0]  response;
        bit [MASK_W-1:0] challenge_mask;
    } verifier_op_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wen = 1'b0;
    logic [VAL_W-1:0]    i_cfg_wdata = '0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_action = 1'b0;
    logic [2:0]          i_key_index = '0;
    logic [VAL_W-1:0]    i_key_word = '0;
    logic [VAL_W-1:0]    i_commitment = '0;
    logic [VAL_W-1:0]    i_response = '0;
    logic [MASK_W-1:0]   i_challenge_mask = '0;
    logic                o_done;
    logic                o_passed;

    verifier_op_t   op_backlog[$];
    bit             expected_verdicts[$];
    int             verifies_open = 0;
    int             ops_sent = 0;
    int             mismatches = 0;
    int             cycle_count = 0;

    // bench view of the block state
    bit [VAL_W-1:0] mod_model = MOD_RESET;
    bit [VAL_W-1:0] key_model[KEYS];

    // stimulus-side knowledge: square roots of the loaded keys
    bit [VAL_W-1:0] gen_mod = MOD_RESET;
    bit [VAL_W-1:0] secret[KEYS];
    bit             key_sq_ok[KEYS];

    zk_square_product_verifier dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wen        (i_cfg_wen),
        .i_cfg_wdata      (i_cfg_wdata),
        .start            (start),
        .busy             (busy),
        .i_action         (i_action),
        .i_key_index      (i_key_index),
        .i_key_word       (i_key_word),
        .i_commitment     (i_commitment),
        .i_response       (i_response),
        .i_challenge_mask (i_challenge_mask),
        .o_done           (o_done),
        .o_passed         (o_passed)
    );

    always #6 i_clk = ~i_clk;

    function automatic bit [VAL_W-1:0] mulmod(bit [VAL_W-1:0] a, bit [VAL_W-1:0] b,
                                              bit [VAL_W-1:0] n);
        bit [63:0] prod;
        prod = 64'(a) * 64'(b);
        return VAL_W'(prod % 64'(n));
    endfunction

    function automatic bit [VAL_W-1:0] clamp_modulus(bit [VAL_W-1:0] v);
        return (v < MOD_MIN) ? MOD_MIN : v;
    endfunction

    function automatic bit square_product_verdict(bit [VAL_W-1:0] commit, bit [VAL_W-1:0] resp,
                                                  bit [MASK_W-1:0] mask);
        bit [VAL_W-1:0] root;
        bit [VAL_W-1:0] left;
        bit [VAL_W-1:0] right;
        root  = resp % mod_model;
        left  = mulmod(root, root, mod_model);
        // no selected key leaves the commitment unreduced
        right = commit;
        for (int i = 0; i < KEYS && i < MASK_W; i++) begin
            if (mask[i]) begin
                right = mulmod(right, key_model[i], mod_model);
            end
        end
        return left == right;
    endfunction

    function automatic void queue_modulus(bit [VAL_W-1:0] v);
        verifier_op_t op;
        op = '{default: '0};
        op.is_cfg  = 1'b1;
        op.cfg_val = v;
        gen_mod    = clamp_modulus(v);
        op_backlog.insert(op_backlog.size(), op);
    endfunction

    function automatic void queue_load(bit [2:0] idx, bit [VAL_W-1:0] word);
        verifier_op_t op;
        op.is_cfg         = 1'b0;
        op.cfg_val        = '0;
        op.action         = 1'b0;
        op.key_index      = idx;
        op.key_word       = word;
        op.commitment     = VAL_W'($urandom());
        op.response       = VAL_W'($urandom());
        op.challenge_mask = MASK_W'($urandom());
        key_sq_ok[idx]    = 1'b0;
        op_backlog.insert(op_backlog.size(), op);
    endfunction

    function automatic void queue_verify(bit [VAL_W-1:0] commit, bit [VAL_W-1:0] resp,
                                         bit [MASK_W-1:0] mask);
        verifier_op_t op;
        op.is_cfg         = 1'b0;
        op.cfg_val        = '0;
        op.action         = 1'b1;
        op.key_index      = 3'($urandom());
        op.key_word       = VAL_W'($urandom());
        op.commitment     = commit;
        op.response       = resp;
        op.challenge_mask = mask;
        op_backlog.insert(op_backlog.size(), op);
    endfunction

    // load the square of a fresh secret
    function automatic void queue_honest_key(bit [2:0] idx);
        bit [VAL_W-1:0] s;
        s = VAL_W'($urandom_range(0, gen_mod - 1));
        queue_load(idx, mulmod(s, s, gen_mod));
        secret[idx]    = s;
        key_sq_ok[idx] = 1'b1;
    endfunction

    // build x = r^2 and y = r * prod(secrets); optionally lift y by multiples of the modulus
    function automatic void queue_honest_proof(bit [MASK_W-1:0] mask, bit tamper);
        bit [VAL_W-1:0] r;
        bit [VAL_W-1:0] x;
        bit [63:0]      y;
        bit [63:0]      span;
        r = VAL_W'($urandom_range(0, gen_mod - 1));
        x = mulmod(r, r, gen_mod);
        y = r;
        for (int i = 0; i < KEYS; i++) begin
            if (mask[i]) begin
                y = mulmod(VAL_W'(y), secret[i], gen_mod);
            end
        end
        span = (64'(VAL_MAX) - y) / 64'(gen_mod);
        if ($urandom_range(2) == 0 && span != 0) begin
            y = y + 64'(gen_mod) * $urandom_range(1, 32'(span));
        end
        if (tamper) begin
            if ($urandom_range(1) == 1) begin
                y = y ^ (64'd1 << $urandom_range(VAL_W - 1));
            end else begin
                x = x ^ (VAL_W'(1) << $urandom_range(VAL_W - 1));
            end
        end
        queue_verify(x, VAL_W'(y), mask);
    endfunction

    function automatic bit [MASK_W-1:0] pick_mask();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0) begin
            return '0;
        end else if (roll == 1) begin
            return '1;
        end
        return MASK_W'($urandom());
    endfunction

    function automatic void queue_random_op();
        int roll;
        roll = $urandom_range(99);
        if (roll < 25) begin
            if ($urandom_range(4) == 0) begin
                queue_load(3'($urandom()), VAL_W'($urandom()));
            end else begin
                queue_honest_key(3'($urandom()));
            end
        end else if (roll < 80) begin
            queue_honest_proof(pick_mask(), 1'b0);
        end else if (roll < 88) begin
            queue_honest_proof(pick_mask(), 1'b1);
        end else begin
            queue_verify(VAL_W'($urandom()), VAL_W'($urandom()), MASK_W'($urandom()));
        end
    endfunction

    // driver: presents queued items on start, writes the modulus only when the block is quiet
    always @(posedge i_clk) begin
        verifier_op_t op;
        logic         nx_start;
        logic         nx_wen;
        bit           calm;
        int           quiet;
        int           idle_left;
        if (!i_rst_n) begin
            start         <= 1'b0;
            i_cfg_wen     <= 1'b0;
            verifies_open = 0;
            quiet         = 0;
            idle_left     = 0;
        end else begin
            nx_start = start;
            nx_wen   = 1'b0;
            calm     = (ops_sent >= 700 && ops_sent < 1000);
            if (i_cfg_wen) begin
                mod_model = clamp_modulus(i_cfg_wdata);
            end
            if (o_done && verifies_open > 0) begin
                verifies_open--;
            end
            if (start && !busy) begin
                if (i_action) begin
                    expected_verdicts.insert(expected_verdicts.size(),
                        square_product_verdict(i_commitment, i_response, i_challenge_mask));
                    verifies_open++;
                end else if (i_key_index < KEYS) begin
                    key_model[i_key_index] = i_key_word;
                end
                nx_start = 1'b0;
                ops_sent++;
            end
            quiet = (!start && !busy) ? quiet + 1 : 0;
            if (!nx_start && !i_cfg_wen && op_backlog.size() != 0) begin
                if (op_backlog[0].is_cfg) begin
                    if (verifies_open == 0 && !busy && quiet >= CFG_SETTLE) begin
                        op = op_backlog.pop_front();
                        i_cfg_wdata <= op.cfg_val;
                        nx_wen = 1'b1;
                    end
                end else if (idle_left != 0) begin
                    idle_left--;
                end else if (!calm && $urandom_range(99) < 10) begin
                    // a long hold-off now and then delays the next item on start
                    if ($urandom_range(9) == 0) begin
                        idle_left = $urandom_range(1, 300);
                    end
                end else begin
                    op = op_backlog.pop_front();
                    i_action         <= op.action;
                    i_key_index      <= op.key_index;
                    i_key_word       <= op.key_word;
                    i_commitment     <= op.commitment;
                    i_response       <= op.response;
                    i_challenge_mask <= op.challenge_mask;
                    nx_start = 1'b1;
                end
            end
            start     <= nx_start;
            i_cfg_wen <= nx_wen;
        end
    end

    // monitor: every strobe must match the oldest predicted verdict
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && o_done) begin
            if (expected_verdicts.size() == 0) begin
                if (mismatches < 10) begin
                    $display("%0t: verdict with no verify pending, passed=%0b", $time, o_passed);
                end
                mismatches++;
            end else begin
                want = expected_verdicts.pop_front();
                if (o_passed !== want) begin
                    if (mismatches < 10) begin
                        $display("%0t: passed expected %0b, got %0b", $time, want, o_passed);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[zk_square_product_verifier] ERROR");
            $finish;
        end
    end

    initial begin
        bit [VAL_W-1:0] r;
        for (int i = 0; i < KEYS; i++) begin
            key_sq_ok[i] = 1'b0;
            secret[i]    = '0;
            key_model[i] = '0;
        end

        // directed: extreme keys, unreduced commitment, zero and full masks
        queue_load(3'd0, VAL_MAX);
        queue_load(3'd1, '0);
        queue_load(3'd2, VAL_W'(1));
        for (int i = 3; i < KEYS; i++) begin
            queue_honest_key(3'(i));
        end
        queue_verify('0, '0, '0);
        queue_verify(VAL_MAX, VAL_MAX, '0);
        queue_verify(VAL_W'(5), VAL_MAX, 8'h01);
        queue_verify(VAL_MAX, '0, 8'h02);
        r = VAL_W'($urandom());
        queue_verify(mulmod(r, r, gen_mod), r, 8'h04);
        queue_verify(VAL_MAX, VAL_MAX, '1);
        queue_honest_proof(8'hF8, 1'b0);
        queue_honest_proof('0, 1'b0);
        for (int i = 0; i < 3; i++) begin
            queue_honest_key(3'(i));
        end
        queue_honest_proof('1, 1'b0);
        queue_honest_proof('1, 1'b1);

        // random phases, each with a fresh key set; every phase but the first writes the modulus first
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                1: queue_modulus('0);
                2: queue_modulus(VAL_W'($urandom_range(3, 1000)));
                3: queue_modulus(MOD_MIN);
                4: queue_modulus(VAL_W'(65521));
                5: queue_modulus(VAL_W'($urandom_range(32'h4000_0000, 32'h7FFF_FFFE)));
                6: queue_modulus(VAL_W'(1));
                7: queue_modulus(VAL_MAX);
                default: ;
            endcase
            for (int i = 0; i < KEYS; i++) begin
                queue_honest_key(3'(i));
            end
            repeat (PER_PHASE) queue_random_op();
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_backlog.size() != 0 || start || verifies_open != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (expected_verdicts.size() != 0) begin
            $display("%0d predicted verdicts never arrived", expected_verdicts.size());
        end
        if (mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("[zk_square_product_verifier] OK");
        end else begin
            $display("[zk_square_product_verifier] ERROR");
        end
        $finish;
    end

endmodule
